[rtl/aho_pkg.sv]
// Shared types and codes for the Aho-Corasick dictionary matcher.
// Holds the request and response payload structs and the queue entry type.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package aho_pkg;

    localparam int CMD_W    = 2;
    localparam int SYM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int WIDX_W   = 10;
    localparam int POS_W    = 20;
    localparam int LEN_W    = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MATCH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NODES_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WORDS_FULL = 2'd3;

    localparam logic [LEN_W-1:0] MAX_WORD_LEN = 8'd255;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] symbol;
        logic             word_end;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WIDX_W-1:0]   word_index;
        logic [POS_W-1:0]    match_start;
        logic [POS_W-1:0]    match_end;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_BUILD   = 2'd1,
        OP_MATCH   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] symbol;
        logic             word_end;
    } aho_op_t;

endpackage

[rtl/aho_front.sv]
// Front end of the matcher: accepts requests, decodes the command and
// holds them in a two-entry queue for the engine. Depends on aho_pkg.
`timescale 1ns / 1ps

module aho_front
    import aho_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  req_t    req,
    output logic    op_valid,
    input  logic    op_pop,
    output aho_op_t op_head
);

    aho_op_t    ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    aho_op_t    op_dec;
    logic       push;
    logic       pop;

    always_comb
    begin
        op_dec.symbol   = req.symbol;
        op_dec.word_end = req.word_end;
        case (req.cmd)
            CMD_INSERT: op_dec.op = OP_INSERT;
            CMD_BUILD:  op_dec.op = OP_BUILD;
            CMD_MATCH:  op_dec.op = OP_MATCH;
            default:    op_dec.op = OP_RESTART;
        endcase
        // The word-end flag only means something for an insert.
        if (req.cmd != CMD_INSERT)
        begin
            op_dec.word_end = 1'b0;
        end
    end

    assign req_ready = (count_reg != 2'd2);
    assign op_valid  = (count_reg != 2'd0);
    assign op_head   = ent_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = op_pop && op_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= op_dec;
        end
    end

endmodule

[rtl/aho_engine.sv]
// Back end of the matcher: trie tables, insert, failure-link build and
// match sequencer, plus the response register. Depends on aho_pkg.
`timescale 1ns / 1ps

module aho_engine
    import aho_pkg::*;
#(
    parameter int NODES         = 4096,
    parameter int WORDS         = 1024,
    parameter int POSITION_BITS = 20
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    output logic    op_pop,
    input  aho_op_t op_head,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output rsp_t    rsp
);

    localparam int NB  = $clog2(NODES);
    localparam int LW  = NB + 1;
    localparam int WB  = $clog2(WORDS);
    localparam int WCW = WB + 1;
    localparam int PB  = POSITION_BITS;

    localparam logic [LW-1:0]  NO_NODE = LW'(NODES);
    localparam logic [WCW-1:0] NO_WORD = WCW'(WORDS);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [LW-1:0]    sib;
    } node_rec_t;

    typedef enum logic [19:0] {
        S_IDLE       = 20'h00001,
        S_LK_HEAD    = 20'h00002,
        S_LK_FIRST   = 20'h00004,
        S_LK_WALK    = 20'h00008,
        S_INS_RET    = 20'h00010,
        S_INS_LINK   = 20'h00020,
        S_INS_FIN    = 20'h00040,
        S_MAT_RET    = 20'h00080,
        S_MAT_FAIL   = 20'h00100,
        S_MAT_WORD   = 20'h00200,
        S_MAT_LEN    = 20'h00400,
        S_MAT_OUT    = 20'h00800,
        S_BLD_POP    = 20'h01000,
        S_BLD_PARENT = 20'h02000,
        S_BLD_FIRST  = 20'h04000,
        S_BLD_CHILD  = 20'h08000,
        S_BLD_SIB    = 20'h10000,
        S_BLD_RET    = 20'h20000,
        S_BLD_FAIL   = 20'h40000,
        S_EMIT       = 20'h80000
    } state_t;

    // Trie and work memories.
    node_rec_t      node_mem  [NODES];
    logic [LW-1:0]  child_mem [NODES];
    logic [LW-1:0]  fail_mem  [NODES];
    logic [WCW-1:0] word_mem  [NODES];
    logic [LEN_W-1:0] len_mem [WORDS];
    logic [NB-1:0]  q_mem     [NODES];

    node_rec_t      node_rd_reg;
    logic [LW-1:0]  child_rd_reg;
    logic [LW-1:0]  fail_rd_reg;
    logic [WCW-1:0] word_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic [NB-1:0]  q_rd_reg;

    logic           node_we;
    logic [NB-1:0]  node_wa;
    node_rec_t      node_wd;
    logic [NB-1:0]  node_ra;
    logic           child_we;
    logic [NB-1:0]  child_wa;
    logic [LW-1:0]  child_wd;
    logic [NB-1:0]  child_ra;
    logic           fail_we;
    logic [NB-1:0]  fail_wa;
    logic [LW-1:0]  fail_wd;
    logic [NB-1:0]  fail_ra;
    logic           word_we;
    logic [NB-1:0]  word_wa;
    logic [WCW-1:0] word_wd;
    logic [NB-1:0]  word_ra;
    logic           len_we;
    logic [WB-1:0]  len_wa;
    logic [LEN_W-1:0] len_wd;
    logic [WB-1:0]  len_ra;
    logic           q_we;
    logic [NB-1:0]  q_wa;
    logic [NB-1:0]  q_wd;
    logic [NB-1:0]  q_ra;

    // Control state.
    state_t         state_reg, state_next;
    state_t         lk_ret_reg, lk_ret_next;
    logic [LW-1:0]  node_count_reg, node_count_next;
    logic [WCW-1:0] word_count_reg, word_count_next;
    logic [NB-1:0]  cursor_reg, cursor_next;
    logic [LEN_W-1:0] ins_len_reg, ins_len_next;
    logic [NB-1:0]  mnode_reg, mnode_next;
    logic [PB-1:0]  mpos_reg, mpos_next;
    logic [LW-1:0]  root_child_reg, root_child_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Working registers.
    logic [SYM_W-1:0] lk_sym_reg, lk_sym_next;
    logic             last_reg, last_next;
    logic [NB-1:0]  lk_node_reg, lk_node_next;
    logic [LW-1:0]  lk_c_reg, lk_c_next;
    logic [LW-1:0]  lk_head_reg, lk_head_next;
    logic           lk_hit_reg, lk_hit_next;
    logic [LW-1:0]  qhead_reg, qhead_next;
    logic [LW-1:0]  qtail_reg, qtail_next;
    logic [NB-1:0]  par_reg, par_next;
    logic [LW-1:0]  pfail_reg, pfail_next;
    logic [LW-1:0]  bc_reg, bc_next;
    logic [LW-1:0]  bsib_reg, bsib_next;
    logic [WB-1:0]  w_reg, w_next;
    rsp_t           res_reg, res_next;
    rsp_t           rsp_reg, rsp_next;

    // Node 0 fields live outside the tables.
    logic [LW-1:0]  first_link;
    logic [LW-1:0]  fail_link;
    logic [WCW-1:0] word_v;
    logic [LW-1:0]  bld_first;
    logic [LW-1:0]  bld_pfail;
    logic [PB-1:0]  len_ext;
    logic [PB-1:0]  start_v;
    logic [PB-1:0]  mpos_inc;

    assign first_link = (lk_node_reg == '0) ? root_child_reg : child_rd_reg;
    assign fail_link  = (lk_node_reg == '0) ? NO_NODE : fail_rd_reg;
    assign word_v     = (mnode_reg == '0) ? NO_WORD : word_rd_reg;
    assign bld_first  = (par_reg == '0) ? root_child_reg : child_rd_reg;
    assign bld_pfail  = (par_reg == '0) ? NO_NODE : fail_rd_reg;
    assign len_ext    = PB'(len_rd_reg);
    assign start_v    = (len_rd_reg != '0 && mpos_reg >= len_ext - PB'(1))
                        ? mpos_reg - (len_ext - PB'(1)) : '0;
    assign mpos_inc   = (mpos_reg == '1) ? mpos_reg : mpos_reg + PB'(1);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        lk_ret_next     = lk_ret_reg;
        node_count_next = node_count_reg;
        word_count_next = word_count_reg;
        cursor_next     = cursor_reg;
        ins_len_next    = ins_len_reg;
        mnode_next      = mnode_reg;
        mpos_next       = mpos_reg;
        root_child_next = root_child_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        lk_sym_next     = lk_sym_reg;
        last_next       = last_reg;
        lk_node_next    = lk_node_reg;
        lk_c_next       = lk_c_reg;
        lk_head_next    = lk_head_reg;
        lk_hit_next     = lk_hit_reg;
        qhead_next      = qhead_reg;
        qtail_next      = qtail_reg;
        par_next        = par_reg;
        pfail_next      = pfail_reg;
        bc_next         = bc_reg;
        bsib_next       = bsib_reg;
        w_next          = w_reg;
        res_next        = res_reg;
        op_pop          = 1'b0;

        node_we  = 1'b0;
        node_wa  = '0;
        node_wd  = '0;
        node_ra  = '0;
        child_we = 1'b0;
        child_wa = '0;
        child_wd = '0;
        child_ra = '0;
        fail_we  = 1'b0;
        fail_wa  = '0;
        fail_wd  = '0;
        fail_ra  = '0;
        word_we  = 1'b0;
        word_wa  = '0;
        word_wd  = '0;
        word_ra  = '0;
        len_we   = 1'b0;
        len_wa   = '0;
        len_wd   = '0;
        len_ra   = '0;
        q_we     = 1'b0;
        q_wa     = '0;
        q_wd     = '0;
        q_ra     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop      = 1'b1;
                    lk_sym_next = op_head.symbol;
                    last_next   = op_head.word_end;
                    case (op_head.op)
                        OP_INSERT:
                        begin
                            if (ins_len_reg == MAX_WORD_LEN ||
                                (op_head.word_end && word_count_reg >= NO_WORD))
                            begin
                                res_next        = '0;
                                res_next.status = ST_WORDS_FULL;
                                cursor_next     = '0;
                                ins_len_next    = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                lk_node_next = cursor_reg;
                                lk_ret_next  = S_INS_RET;
                                state_next   = S_LK_HEAD;
                            end
                        end
                        OP_BUILD:
                        begin
                            q_we       = 1'b1;
                            qhead_next = '0;
                            qtail_next = LW'(1);
                            state_next = S_BLD_POP;
                        end
                        OP_MATCH:
                        begin
                            lk_node_next = mnode_reg;
                            lk_ret_next  = S_MAT_RET;
                            state_next   = S_LK_HEAD;
                        end
                        default:
                        begin
                            mnode_next = '0;
                            mpos_next  = '0;
                            res_next   = '0;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_LK_HEAD:
            begin
                child_ra   = lk_node_reg;
                state_next = S_LK_FIRST;
            end
            S_LK_FIRST:
            begin
                lk_head_next = first_link;
                if (first_link >= node_count_reg)
                begin
                    lk_hit_next = 1'b0;
                    state_next  = lk_ret_reg;
                end
                else
                begin
                    node_ra    = first_link[NB-1:0];
                    lk_c_next  = first_link;
                    state_next = S_LK_WALK;
                end
            end
            S_LK_WALK:
            begin
                if (node_rd_reg.symbol == lk_sym_reg)
                begin
                    lk_hit_next = 1'b1;
                    state_next  = lk_ret_reg;
                end
                else if (node_rd_reg.sib >= node_count_reg)
                begin
                    lk_hit_next = 1'b0;
                    state_next  = lk_ret_reg;
                end
                else
                begin
                    node_ra   = node_rd_reg.sib[NB-1:0];
                    lk_c_next = node_rd_reg.sib;
                end
            end
            S_INS_RET:
            begin
                if (lk_hit_reg)
                begin
                    state_next = S_INS_FIN;
                end
                else if (node_count_reg >= NO_NODE)
                begin
                    res_next        = '0;
                    res_next.status = ST_NODES_FULL;
                    cursor_next     = '0;
                    ins_len_next    = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    // New node goes to the head of the cursor's child list.
                    node_we         = 1'b1;
                    node_wa         = node_count_reg[NB-1:0];
                    node_wd.symbol  = lk_sym_reg;
                    node_wd.sib     = lk_head_reg;
                    child_we        = 1'b1;
                    child_wa        = node_count_reg[NB-1:0];
                    child_wd        = NO_NODE;
                    fail_we         = 1'b1;
                    fail_wa         = node_count_reg[NB-1:0];
                    fail_wd         = '0;
                    word_we         = 1'b1;
                    word_wa         = node_count_reg[NB-1:0];
                    word_wd         = NO_WORD;
                    lk_c_next       = node_count_reg;
                    node_count_next = node_count_reg + LW'(1);
                    state_next      = S_INS_LINK;
                end
            end
            S_INS_LINK:
            begin
                if (cursor_reg == '0)
                begin
                    root_child_next = lk_c_reg;
                end
                else
                begin
                    child_we = 1'b1;
                    child_wa = cursor_reg;
                    child_wd = lk_c_reg;
                end
                state_next = S_INS_FIN;
            end
            S_INS_FIN:
            begin
                res_next = '0;
                if (last_reg)
                begin
                    word_we             = 1'b1;
                    word_wa             = lk_c_reg[NB-1:0];
                    word_wd             = word_count_reg;
                    len_we              = 1'b1;
                    len_wa              = word_count_reg[WB-1:0];
                    len_wd              = ins_len_reg + LEN_W'(1);
                    res_next.word_index = WIDX_W'(word_count_reg);
                    word_count_next     = word_count_reg + WCW'(1);
                    cursor_next         = '0;
                    ins_len_next        = '0;
                end
                else
                begin
                    cursor_next  = lk_c_reg[NB-1:0];
                    ins_len_next = ins_len_reg + LEN_W'(1);
                end
                state_next = S_EMIT;
            end
            S_MAT_RET:
            begin
                if (lk_hit_reg)
                begin
                    mnode_next = lk_c_reg[NB-1:0];
                    state_next = S_MAT_WORD;
                end
                else
                begin
                    fail_ra    = lk_node_reg;
                    state_next = S_MAT_FAIL;
                end
            end
            S_MAT_FAIL:
            begin
                if (fail_link >= node_count_reg)
                begin
                    mnode_next = '0;
                    state_next = S_MAT_WORD;
                end
                else
                begin
                    lk_node_next = fail_link[NB-1:0];
                    state_next   = S_LK_HEAD;
                end
            end
            S_MAT_WORD:
            begin
                word_ra    = mnode_reg;
                state_next = S_MAT_LEN;
            end
            S_MAT_LEN:
            begin
                if (word_v >= NO_WORD)
                begin
                    res_next   = '0;
                    mpos_next  = mpos_inc;
                    state_next = S_EMIT;
                end
                else
                begin
                    len_ra     = word_v[WB-1:0];
                    w_next     = word_v[WB-1:0];
                    state_next = S_MAT_OUT;
                end
            end
            S_MAT_OUT:
            begin
                res_next.status      = ST_MATCH;
                res_next.word_index  = WIDX_W'(w_reg);
                res_next.match_start = POS_W'(start_v);
                res_next.match_end   = POS_W'(mpos_reg);
                mpos_next            = mpos_inc;
                state_next           = S_EMIT;
            end
            S_BLD_POP:
            begin
                if (qhead_reg == qtail_reg)
                begin
                    res_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    q_ra       = qhead_reg[NB-1:0];
                    qhead_next = qhead_reg + LW'(1);
                    state_next = S_BLD_PARENT;
                end
            end
            S_BLD_PARENT:
            begin
                par_next   = q_rd_reg;
                child_ra   = q_rd_reg;
                fail_ra    = q_rd_reg;
                state_next = S_BLD_FIRST;
            end
            S_BLD_FIRST:
            begin
                bc_next    = bld_first;
                pfail_next = bld_pfail;
                state_next = S_BLD_CHILD;
            end
            S_BLD_CHILD:
            begin
                if (bc_reg >= node_count_reg)
                begin
                    state_next = S_BLD_POP;
                end
                else
                begin
                    q_we       = 1'b1;
                    q_wa       = qtail_reg[NB-1:0];
                    q_wd       = bc_reg[NB-1:0];
                    qtail_next = qtail_reg + LW'(1);
                    node_ra    = bc_reg[NB-1:0];
                    state_next = S_BLD_SIB;
                end
            end
            S_BLD_SIB:
            begin
                bsib_next = node_rd_reg.sib;
                if (pfail_reg >= node_count_reg)
                begin
                    // Children of the root fail back to the root.
                    fail_we    = 1'b1;
                    fail_wa    = bc_reg[NB-1:0];
                    fail_wd    = '0;
                    bc_next    = node_rd_reg.sib;
                    state_next = S_BLD_CHILD;
                end
                else
                begin
                    lk_node_next = pfail_reg[NB-1:0];
                    lk_sym_next  = node_rd_reg.symbol;
                    lk_ret_next  = S_BLD_RET;
                    state_next   = S_LK_HEAD;
                end
            end
            S_BLD_RET:
            begin
                if (lk_hit_reg)
                begin
                    fail_we    = 1'b1;
                    fail_wa    = bc_reg[NB-1:0];
                    fail_wd    = lk_c_reg;
                    bc_next    = bsib_reg;
                    state_next = S_BLD_CHILD;
                end
                else
                begin
                    fail_ra    = lk_node_reg;
                    state_next = S_BLD_FAIL;
                end
            end
            S_BLD_FAIL:
            begin
                if (fail_link >= node_count_reg)
                begin
                    fail_we    = 1'b1;
                    fail_wa    = bc_reg[NB-1:0];
                    fail_wd    = '0;
                    bc_next    = bsib_reg;
                    state_next = S_BLD_CHILD;
                end
                else
                begin
                    lk_node_next = fail_link[NB-1:0];
                    state_next   = S_LK_HEAD;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= LW'(1);
            word_count_reg <= '0;
            cursor_reg     <= '0;
            ins_len_reg    <= '0;
            mnode_reg      <= '0;
            mpos_reg       <= '0;
            root_child_reg <= NO_NODE;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            word_count_reg <= word_count_next;
            cursor_reg     <= cursor_next;
            ins_len_reg    <= ins_len_next;
            mnode_reg      <= mnode_next;
            mpos_reg       <= mpos_next;
            root_child_reg <= root_child_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lk_ret_reg  <= lk_ret_next;
        lk_sym_reg  <= lk_sym_next;
        last_reg    <= last_next;
        lk_node_reg <= lk_node_next;
        lk_c_reg    <= lk_c_next;
        lk_head_reg <= lk_head_next;
        lk_hit_reg  <= lk_hit_next;
        qhead_reg   <= qhead_next;
        qtail_reg   <= qtail_next;
        par_reg     <= par_next;
        pfail_reg   <= pfail_next;
        bc_reg      <= bc_next;
        bsib_reg    <= bsib_next;
        w_reg       <= w_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        node_rd_reg <= node_mem[node_ra];
    end

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_wa] <= child_wd;
        end
        child_rd_reg <= child_mem[child_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_wa] <= fail_wd;
        end
        fail_rd_reg <= fail_mem[fail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_wa] <= word_wd;
        end
        word_rd_reg <= word_mem[word_ra];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        len_rd_reg <= len_mem[len_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        q_rd_reg <= q_mem[q_ra];
    end

`ifndef SYNTHESIS
    a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg != '0 && node_count_reg <= NO_NODE)
        else $error("node count out of range");

    a_word_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_count_reg <= NO_WORD)
        else $error("word count out of range");

    a_match_node_live: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, mnode_reg} < node_count_reg)
        else $error("match node beyond allocated nodes");

    a_cursor_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg == '0) == (ins_len_reg == '0))
        else $error("insert cursor and length disagree");
`endif

endmodule

[rtl/aho_corasick_matcher.sv]
// Top level of the Aho-Corasick dictionary matcher over 16-bit symbols.
// Instantiates the request front end (aho_front) and the engine (aho_engine).
// Depends on aho_pkg.
`timescale 1ns / 1ps

// Each request is one command: insert a word symbol, build failure links,
// match a text symbol, or restart the text. Every request returns exactly
// one response, in request order. A request is decoded and parked in a
// two-entry queue, so new requests are taken while the engine works and
// while a finished response waits in the output register. The engine reads
// its trie tables through registered single-port reads, one table access
// per cycle. A stalled response holds the engine until it is taken. An
// insert scans the siblings at the cursor node and allocates a node when
// the symbol is not found; an insert refused up front for length or a
// full word table goes straight to its response. A match takes the
// request, then runs goto lookups, each scanning siblings, reads the
// failure link after each failed lookup, then fetches the word and its
// length and loads the response register. A build visits each node and
// runs its failure lookups, each a lookup as in a match plus a failure
// link read. No clearing pass is needed after reset; the root's child
// link lives in a register and new nodes initialize their own entries.
// Only the longest word ending at a node is reported, and text positions
// saturate at the all-ones value of POSITION_BITS.
module aho_corasick_matcher
    import aho_pkg::*;
#(
    parameter int NODES         = 4096,
    parameter int WORDS         = 1024,
    parameter int POSITION_BITS = 20
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Decoded requests waiting for the engine.
    logic    op_valid;
    logic    op_pop;
    aho_op_t op_head;

    aho_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .op_valid  (op_valid),
        .op_pop    (op_pop),
        .op_head   (op_head)
    );

    aho_engine #(
        .NODES         (NODES),
        .WORDS         (WORDS),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_pop    (op_pop),
        .op_head   (op_head),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
